### sv/eqs_pkg.sv
package eqs_pkg;

   // result fields are always this wide
   localparam int unsigned OUT_W = 32;

   // longest run a single input item may produce
   localparam int unsigned MAX_RESULTS = 47;
   localparam int unsigned STEP_W      = $clog2(MAX_RESULTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_OUT
   } eqs_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture and order the operands
      logic init_div;  // load the dividend into the divider, clear remainder and bit count
      logic div_step;  // one restoring-division bit
      logic advance;   // divisor becomes dividend, remainder becomes divisor
   } eqs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dvs_zero;  // current divisor is zero
      logic div_done;  // this is the final bit of the division
      logic last;      // result on the output ends the run
   } eqs_status_type;

endpackage

### sv/eqs_dpath.sv
module eqs_dpath
   import eqs_pkg::*;
#(
   parameter int unsigned WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  eqs_cmd_type         cmd,
   output eqs_status_type      status,
   input  logic [OUT_W-1:0]    first_operand,
   input  logic [OUT_W-1:0]    second_operand,
   output logic [OUT_W-1:0]    quotient,
   output logic [OUT_W-1:0]    divisor,
   output logic [OUT_W-1:0]    remainder_out,
   output logic                last_step,
   output logic                zero_operand
);

   localparam int unsigned CNT_W = $clog2(WIDTH);

   logic [WIDTH-1:0]  dvd_ff, dvd_in;
   logic [WIDTH-1:0]  dvs_ff, dvs_in;
   logic [WIDTH-1:0]  quo_ff, quo_in;
   logic [WIDTH-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              zero_ff, zero_in;

   logic [WIDTH-1:0]  op_x;
   logic [WIDTH-1:0]  op_y;
   logic [WIDTH:0]    trial;
   logic [WIDTH:0]    diff;
   logic              last;

   assign op_x  = WIDTH'(first_operand);
   assign op_y  = WIDTH'(second_operand);

   // shift in the next dividend bit and try to subtract
   assign trial = {rem_ff, quo_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   assign last = zero_ff || (rem_ff == '0) || (step_ff == STEP_W'(MAX_RESULTS - 1));

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      step_in = step_ff;
      zero_in = zero_ff;
      if (cmd.load) begin
         if (op_x > op_y) begin
            dvd_in = op_x;
            dvs_in = op_y;
         end else begin
            dvd_in = op_y;
            dvs_in = op_x;
         end
         zero_in = (op_x == '0) || (op_y == '0);
         quo_in  = '0;
         rem_in  = '0;
         step_in = '0;
      end
      if (cmd.init_div) begin
         quo_in = dvd_ff;
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.advance) begin
         dvd_in  = dvs_ff;
         dvs_in  = rem_ff;
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvd_ff  <= '0;
         dvs_ff  <= '0;
         quo_ff  <= '0;
         rem_ff  <= '0;
         cnt_ff  <= '0;
         step_ff <= '0;
         zero_ff <= 1'b0;
      end else begin
         dvd_ff  <= dvd_in;
         dvs_ff  <= dvs_in;
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_in;
         step_ff <= step_in;
         zero_ff <= zero_in;
      end
   end

   assign status.dvs_zero = (dvs_ff == '0);
   assign status.div_done = (cnt_ff == CNT_W'(WIDTH - 1));
   assign status.last     = last;

   // zero operand case reports the larger operand as the divisor
   assign quotient      = OUT_W'(quo_ff);
   assign divisor       = zero_ff ? OUT_W'(dvd_ff) : OUT_W'(dvs_ff);
   assign remainder_out = OUT_W'(rem_ff);
   assign last_step     = last;
   assign zero_operand  = zero_ff;

endmodule

### sv/eqs_ctrl.sv
module eqs_ctrl
   import eqs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  eqs_status_type status,
   output eqs_cmd_type    cmd
);

   eqs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.dvs_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.init_div = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_START;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### sv/euclid_quotient_sequence.sv
// sequence: the operands are ordered as they are taken, the divider is seeded in the start
// state and runs in the divide state, and each result is held in the output state until taken
// one input item at a time: no new input is taken until its last result is transferred; the
// one-bit-per-cycle restoring divider runs for every step; up to 45 steps for 32-bit operands
// a zero operand skips the divider and gives its single result from the output state
// reset: synchronous active-high, returns the controller to idle and clears flags
module euclid_quotient_sequence
   import eqs_pkg::*;
#(
   parameter int unsigned WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   // operand channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [OUT_W-1:0] req_first_operand,
   input  logic [OUT_W-1:0] req_second_operand,
   // step result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [OUT_W-1:0] rsp_quotient,
   output logic [OUT_W-1:0] rsp_divisor,
   output logic [OUT_W-1:0] rsp_remainder_out,
   output logic             rsp_last_step,
   output logic             rsp_zero_operand
);

   // command and status between the sequencer and the datapath
   eqs_cmd_type    cmd;
   eqs_status_type status;

   // sequencer: idle -> order operands -> start -> divide -> hold result until transfer, looping back
   // to start until the remainder reaches zero or MAX_RESULTS results are out; a zero divisor skips divide
   eqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // operand registers, restoring divider and step counter; result fields come
   // straight from its registers, which hold still while a result waits
   eqs_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .first_operand  (req_first_operand),
      .second_operand (req_second_operand),
      .quotient       (rsp_quotient),
      .divisor        (rsp_divisor),
      .remainder_out  (rsp_remainder_out),
      .last_step      (rsp_last_step),
      .zero_operand   (rsp_zero_operand)
   );

endmodule

### verif/eqs_step_checker.sv
`timescale 1ns / 100ps

module eqs_step_checker
   import eqs_pkg::*;
#(
   parameter int unsigned WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [OUT_W-1:0] req_first_operand,
   input  logic [OUT_W-1:0] req_second_operand,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [OUT_W-1:0] rsp_quotient,
   input  logic [OUT_W-1:0] rsp_divisor,
   input  logic [OUT_W-1:0] rsp_remainder_out,
   input  logic             rsp_last_step,
   input  logic             rsp_zero_operand,
   output int               mismatch_count,
   output int               steps_due
);

   localparam logic [63:0] OPER_MASK = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);

   typedef struct packed {
      logic [OUT_W-1:0] quotient;
      logic [OUT_W-1:0] divisor;
      logic [OUT_W-1:0] remainder_out;
      logic             last_step;
      logic             zero_operand;
   } div_step_type;

   div_step_type expected_steps [$];

   assign steps_due = expected_steps.size();

   function automatic void predict_euclid_steps(input logic [OUT_W-1:0] first,
                                                input logic [OUT_W-1:0] second);
      logic [63:0]  x;
      logic [63:0]  y;
      logic [63:0]  num;
      logic [63:0]  den;
      logic [63:0]  quo;
      logic [63:0]  rem;
      int           n;
      bit           done;
      div_step_type entry;
      x   = 64'(first) & OPER_MASK;
      y   = 64'(second) & OPER_MASK;
      num = (x > y) ? x : y;
      den = (x > y) ? y : x;
      // zero smaller operand: one flagged result, the larger operand is the gcd
      if (den == 0) begin
         entry = '{quotient: '0, divisor: num[OUT_W-1:0],
                   remainder_out: '0, last_step: 1'b1,
                   zero_operand: 1'b1};
         expected_steps = {expected_steps, entry};
         return;
      end
      n    = 0;
      done = 1'b0;
      while (!done) begin
         quo  = num / den;
         rem  = num % den;
         done = (rem == 0) || (n + 1 >= MAX_RESULTS);
         entry = '{quotient: quo[OUT_W-1:0], divisor: den[OUT_W-1:0],
                   remainder_out: rem[OUT_W-1:0], last_step: done,
                   zero_operand: 1'b0};
         expected_steps = {expected_steps, entry};
         n++;
         num = den;
         den = rem;
      end
   endfunction

   function automatic void check_field(input string field, input logic [OUT_W-1:0] want,
                                       input logic [OUT_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      div_step_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_steps.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected result, expected none got quotient %0d divisor %0d",
                        $time, rsp_quotient, rsp_divisor);
            end else begin
               want = expected_steps.pop_front();
               check_field("quotient", want.quotient, rsp_quotient);
               check_field("divisor", want.divisor, rsp_divisor);
               check_field("remainder_out", want.remainder_out, rsp_remainder_out);
               check_field("last_step", OUT_W'(want.last_step), OUT_W'(rsp_last_step));
               check_field("zero_operand", OUT_W'(want.zero_operand), OUT_W'(rsp_zero_operand));
            end
         end
         // a new input cannot yield a result on its own transfer edge
         if (req_valid && !req_stall)
            predict_euclid_steps(req_first_operand, req_second_operand);
      end
   end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb
   import eqs_pkg::*;
();

   localparam int unsigned WIDTH        = 32;
   localparam int          RANDOM_PAIRS = 240;
   localparam int          IDLE_PCT     = 12;
   localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

   bit               clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [OUT_W-1:0] req_first_operand;
   logic [OUT_W-1:0] req_second_operand;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [OUT_W-1:0] rsp_quotient;
   logic [OUT_W-1:0] rsp_divisor;
   logic [OUT_W-1:0] rsp_remainder_out;
   logic             rsp_last_step;
   logic             rsp_zero_operand;

   int mismatch_count;
   int steps_due;

   // while set, neither side idles
   bit calm;

   // fibonacci numbers, consecutive pairs are the longest euclid runs
   logic [63:0] fib [0:48];

   euclid_quotient_sequence #(.WIDTH(WIDTH)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient       (rsp_quotient),
      .rsp_divisor        (rsp_divisor),
      .rsp_remainder_out  (rsp_remainder_out),
      .rsp_last_step      (rsp_last_step),
      .rsp_zero_operand   (rsp_zero_operand)
   );

   eqs_step_checker #(.WIDTH(WIDTH)) step_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient       (rsp_quotient),
      .rsp_divisor        (rsp_divisor),
      .rsp_remainder_out  (rsp_remainder_out),
      .rsp_last_step      (rsp_last_step),
      .rsp_zero_operand   (rsp_zero_operand),
      .mismatch_count     (mismatch_count),
      .steps_due          (steps_due)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side: random stalls, changed only at the falling edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // one operand transfer, entered and left at a falling edge; random idle
   // cycles go in front, valid stays high into the next pair when none are drawn
   task automatic send_pair(input logic [31:0] first, input logic [31:0] second);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_first_operand  = first;
      req_second_operand = second;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // hold the sender until every predicted step has come back
   task automatic drain_steps();
      req_valid = 1'b0;
      while (steps_due != 0) @(negedge clock);
   endtask

   // random operand pair, weighted toward long and special runs
   task automatic make_pair(output logic [31:0] first, output logic [31:0] second);
      logic [31:0] swap;
      logic [31:0] scale;
      int          k;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 25) begin
         // plain random, every bit toggles
         first  = $urandom;
         second = $urandom;
      end else if (pick < 40) begin
         // random magnitudes so quotients span small and large
         first  = $urandom >> $urandom_range(31);
         second = $urandom >> $urandom_range(31);
      end else if (pick < 48) begin
         // zero operand, now and then both zero
         first  = ($urandom_range(7) == 0) ? 32'd0 : ($urandom >> $urandom_range(31));
         second = 32'd0;
      end else if (pick < 53) begin
         // equal operands give a single step
         first  = $urandom >> $urandom_range(31);
         second = first;
      end else if (pick < 68) begin
         // shared factor so the gcd is not trivially one
         scale  = $urandom_range(1, 65535);
         first  = scale * $urandom_range(1, 65535);
         second = scale * $urandom_range(1, 65535);
      end else if (pick < 85) begin
         // scaled consecutive fibonacci numbers: long runs of unit quotients
         k      = $urandom_range(2, 46);
         scale  = $urandom_range(1, 32'(64'hFFFF_FFFF / fib[k + 1]));
         first  = scale * fib[k + 1][31:0];
         second = scale * fib[k][31:0];
      end else begin
         // one operand divides the other
         first  = $urandom >> $urandom_range(1, 31);
         if (first == 0) first = 32'd1;
         second = first * $urandom_range(1, 32'(ALL_ONES / first));
      end
      if ($urandom_range(1)) begin
         swap   = first;
         first  = second;
         second = swap;
      end
   endtask

   initial begin
      logic [31:0] first;
      logic [31:0] second;
      int          n;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_first_operand  = '0;
      req_second_operand = '0;
      calm               = 1'b0;
      fib[0] = 64'd0;
      fib[1] = 64'd1;
      for (n = 2; n <= 48; n++) fib[n] = fib[n - 1] + fib[n - 2];
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // directed: zero operands, equal operands, extremes, longest 32-bit run
      send_pair(32'd0, 32'd0);
      send_pair(32'd0, ALL_ONES);
      send_pair(ALL_ONES, 32'd0);
      send_pair(32'd1, 32'd0);
      send_pair(32'd0, 32'd1);
      send_pair(32'd1, 32'd1);
      send_pair(32'd7, 32'd7);
      send_pair(ALL_ONES, ALL_ONES);
      send_pair(ALL_ONES, ALL_ONES - 32'd1);
      send_pair(ALL_ONES - 32'd1, ALL_ONES);
      send_pair(32'd1, ALL_ONES);
      send_pair(ALL_ONES, 32'd1);
      send_pair(fib[47][31:0], fib[46][31:0]);
      send_pair(fib[46][31:0], fib[47][31:0]);
      send_pair(32'd12, 32'd18);
      send_pair(32'd18, 32'd12);
      send_pair(32'h8000_0000, 32'h4000_0000);
      send_pair(32'd1000000007, 32'd998244353);
      send_pair(32'h5555_5555, 32'hAAAA_AAAA);
      send_pair(32'd3, 32'd5);
      drain_steps();

      // random part, with a stretch of no idling and one full drain midway
      for (n = 0; n < RANDOM_PAIRS; n++) begin
         calm = (n >= 90) && (n < 150);
         if (n == 200) drain_steps();
         make_pair(first, second);
         send_pair(first, second);
      end
      calm = 1'b0;
      drain_steps();

      // room for any stray result after the last expected one
      repeat (4 * WIDTH) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // far beyond the slowest legal run: every item at 47 division steps plus stalls
   initial begin
      #60_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### sim.f
sv/eqs_pkg.sv
sv/eqs_dpath.sv
sv/eqs_ctrl.sv
sv/euclid_quotient_sequence.sv
verif/eqs_step_checker.sv
verif/tb.sv
